/* hw/rtl/emvt_pkg.sv */
// Package: shared widths, constants, register indexes and types of the encoder velocity tracker.
package emvt_pkg;

   // Field widths
   localparam int RAW_ANGLE_BITS = 12;
   localparam int TIME_BITS      = 32;
   localparam int QUAD_BITS      = 2;
   localparam int TURN_BITS      = 16;
   localparam int POS_BITS       = 32;
   localparam int VEL_BITS       = 21;
   localparam int LIMIT_BITS     = 20;
   localparam int WEIGHT_BITS    = 16;
   localparam int FRAC_BITS      = 16;
   localparam int SMOOTH_BITS    = 37;

   // Default angle resolution
   localparam int ANGLE_BITS_DEFAULT = 12;

   // Velocity arithmetic
   localparam int                  QUOT_BITS      = 20;
   localparam int                  DIVIDEND_BITS  = 52;
   localparam logic [LIMIT_BITS-1:0] MICROS_PER_SEC = LIMIT_BITS'(1000000);

   // Turn counter limits
   localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
   localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

   // Quadrant codes
   localparam logic [QUAD_BITS-1:0] QUAD_FIRST = 2'd0;
   localparam logic [QUAD_BITS-1:0] QUAD_LAST  = 2'd3;

   // Configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 20;
   localparam logic [CSR_INDEX_BITS-1:0] REG_VELOCITY_LIMIT = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FILTER_WEIGHT  = 1'b1;
   localparam logic [LIMIT_BITS-1:0]  VELOCITY_LIMIT_RESET = LIMIT_BITS'(409600);
   localparam logic [WEIGHT_BITS-1:0] FILTER_WEIGHT_RESET  = WEIGHT_BITS'(64553);

   // Tracker results for the current transaction
   typedef struct packed {
      logic [QUAD_BITS-1:0]        quadrant;
      logic signed [TURN_BITS-1:0] turn_count;
      logic signed [POS_BITS-1:0]  position;
   } track_type;

   // Divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* hw/rtl/emvt_if.sv */
// Interfaces: request and response channels of the encoder velocity tracker.
interface emvt_req_if;
   logic                                valid;
   logic                                ready;
   logic [emvt_pkg::RAW_ANGLE_BITS-1:0] raw_angle;
   logic                                at_bottom_limit;
   logic [emvt_pkg::TIME_BITS-1:0]      time_us;

   modport source (output valid, output raw_angle, output at_bottom_limit, output time_us,
                   input ready);
   modport sink   (input valid, input raw_angle, input at_bottom_limit, input time_us,
                   output ready);
endinterface

interface emvt_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [emvt_pkg::QUAD_BITS-1:0]        quadrant;
   logic signed [emvt_pkg::TURN_BITS-1:0] turn_count;
   logic signed [emvt_pkg::POS_BITS-1:0]  position_counts;
   logic signed [emvt_pkg::VEL_BITS-1:0]  raw_velocity;
   logic signed [emvt_pkg::VEL_BITS-1:0]  filtered_velocity;

   modport source (output valid, output quadrant, output turn_count, output position_counts,
                   output raw_velocity, output filtered_velocity, input ready);
   modport sink   (input valid, input quadrant, input turn_count, input position_counts,
                   input raw_velocity, input filtered_velocity, output ready);
endinterface

/* hw/rtl/emvt_tracker.sv */
// Tracker: angle inversion, quadrant wrap turn counting, homing and position.
module emvt_tracker #(
   parameter int ANGLE_BITS = emvt_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic [emvt_pkg::RAW_ANGLE_BITS-1:0] raw_angle,
   input  logic                                at_bottom_limit,
   output emvt_pkg::track_type                 trk
);

   localparam int WIDE_BITS = emvt_pkg::POS_BITS + 2;
   localparam logic [ANGLE_BITS:0] FULL   = (ANGLE_BITS+1)'(1) << ANGLE_BITS;
   localparam logic [ANGLE_BITS:0] BOUND1 = FULL >> 2;
   localparam logic [ANGLE_BITS:0] BOUND2 = FULL >> 1;
   localparam logic [ANGLE_BITS:0] BOUND3 = BOUND1 + BOUND2;

   logic [emvt_pkg::QUAD_BITS-1:0]        last_quad_ff, last_quad_in;
   logic signed [emvt_pkg::TURN_BITS-1:0] turns_ff, turns_in, turns_step;
   logic [ANGLE_BITS:0]                   offset_ff, offset_in;
   logic signed [emvt_pkg::POS_BITS-1:0]  pos_ff, pos_in;

   logic [ANGLE_BITS-1:0]         raw;
   logic [ANGLE_BITS:0]           angle;
   logic signed [WIDE_BITS-1:0]   angle_ext, turns_ext, offset_ext, pos_wide;

   always_comb begin
      raw   = ANGLE_BITS'(raw_angle);
      angle = FULL - {1'b0, raw};

      if (angle < BOUND1) begin
         last_quad_in = 2'd0;
      end else if (angle < BOUND2) begin
         last_quad_in = 2'd1;
      end else if (angle < BOUND3) begin
         last_quad_in = 2'd2;
      end else begin
         last_quad_in = 2'd3;
      end

      // wrap forward adds a turn, wrap backward removes one, both saturate
      turns_step = turns_ff;
      if (last_quad_ff == emvt_pkg::QUAD_LAST && last_quad_in == emvt_pkg::QUAD_FIRST) begin
         if (turns_ff != emvt_pkg::TURN_MAX) begin
            turns_step = turns_ff + 16'sd1;
         end
      end else if (last_quad_ff == emvt_pkg::QUAD_FIRST &&
                   last_quad_in == emvt_pkg::QUAD_LAST) begin
         if (turns_ff != emvt_pkg::TURN_MIN) begin
            turns_step = turns_ff - 16'sd1;
         end
      end

      angle_ext  = $signed(WIDE_BITS'(angle));
      turns_ext  = WIDE_BITS'(turns_step) <<< ANGLE_BITS;
      offset_ext = $signed(WIDE_BITS'(offset_ff));
      pos_wide   = angle_ext + turns_ext - offset_ext;

      if (at_bottom_limit) begin
         turns_in  = '0;
         offset_in = angle;
         pos_in    = '0;
      end else begin
         turns_in  = turns_step;
         offset_in = offset_ff;
         pos_in    = $signed(pos_wide[emvt_pkg::POS_BITS-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_quad_ff <= '0;
         turns_ff     <= '0;
         offset_ff    <= '0;
         pos_ff       <= '0;
      end else if (step) begin
         last_quad_ff <= last_quad_in;
         turns_ff     <= turns_in;
         offset_ff    <= offset_in;
         pos_ff       <= pos_in;
      end
   end

   assign trk.quadrant   = last_quad_ff;
   assign trk.turn_count = turns_ff;
   assign trk.position   = pos_ff;

endmodule

/* hw/rtl/emvt_divider.sv */
// Divider: restoring serial divider, one quotient bit per cycle.
module emvt_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [emvt_pkg::DIVIDEND_BITS-1:0] dividend,
   input  logic [emvt_pkg::TIME_BITS-1:0]     divisor,
   output logic [emvt_pkg::QUOT_BITS-1:0]     quotient,
   output emvt_pkg::div_status_type           status
);

   localparam int QB       = emvt_pkg::QUOT_BITS;
   localparam int DB       = emvt_pkg::TIME_BITS;
   localparam int CNT_BITS = $clog2(QB + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DB-1:0]       rem_ff, rem_in;
   logic [DB-1:0]       dvsr_ff;
   logic [QB-1:0]       low_ff, low_in;
   logic [QB-1:0]       quot_ff, quot_in;
   logic [DB:0]         trial;

   // caller guarantees dividend < divisor * 2^QB, so the top part starts below divisor
   always_comb begin
      trial   = {rem_ff, low_ff[QB-1]} - {1'b0, dvsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(QB);
         rem_in  = dividend[emvt_pkg::DIVIDEND_BITS-1:QB];
         low_in  = dividend[QB-1:0];
         quot_in = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CNT_BITS'(1);
         low_in = low_ff << 1;
         if (!trial[DB]) begin
            rem_in  = trial[DB-1:0];
            quot_in = {quot_ff[QB-2:0], 1'b1};
         end else begin
            rem_in  = {rem_ff[DB-2:0], low_ff[QB-1]};
            quot_in = {quot_ff[QB-2:0], 1'b0};
         end
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      if (start) begin
         dvsr_ff <= divisor;
      end
   end

   assign quotient    = quot_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

/* hw/rtl/multiturn_encoder_velocity_tracker.sv */
// Top level: multiturn absolute encoder position and velocity tracker.
//
// Usage
//   req_if: one sensor reading per transaction (raw angle, bottom limit switch,
//   microsecond timestamp). rsp_if: one result per transaction (quadrant, turn
//   count, homed position, spike-rejected raw velocity, smoothed velocity).
//   csr_* is a write-only register port (velocity limit, filter weight);
//   write it only while no transaction is in flight.
// Timing
//   Sequencer steps: position difference, constant-width multiplies, bound
//   check, serial divide, filter. Skipping the divide (no elapsed time, or the
//   bound check rejects the velocity) takes the sequencer from the bound check
//   straight to the filter; otherwise the 20-step serial divider runs in between.
//   req_if.ready is high only while the sequencer is idle.
// Reset
//   Synchronous, active high: all tracking state clears to zero, registers
//   take their defaults, rsp_if.valid drops.
// Stalls
//   The result sits in an output register, so a new request is taken while it
//   waits; a finished result holds the sequencer only while the previous one
//   is still not taken.
module multiturn_encoder_velocity_tracker #(
   parameter int ANGLE_BITS = emvt_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   emvt_req_if.sink                            req_if,
   emvt_rsp_if.source                          rsp_if,
   input  logic                                csr_we,
   input  logic [emvt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [emvt_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int TB     = emvt_pkg::TIME_BITS;
   localparam int PB     = emvt_pkg::POS_BITS;
   localparam int VB     = emvt_pkg::VEL_BITS;
   localparam int LB     = emvt_pkg::LIMIT_BITS;
   localparam int WB     = emvt_pkg::WEIGHT_BITS;
   localparam int FB     = emvt_pkg::FRAC_BITS;
   localparam int SB     = emvt_pkg::SMOOTH_BITS;
   localparam int QB     = emvt_pkg::QUOT_BITS;
   localparam int NB     = emvt_pkg::DIVIDEND_BITS;
   localparam int BB     = NB + 1;              // bound product width
   localparam int P1B    = SB + WB + 1;         // smoothed times weight
   localparam int P2B    = VB + WB + 2;         // velocity times complement
   localparam int SUMB   = SB + 3;              // filter sum before clamp
   localparam int FRB    = SB + 1;              // rounded smoothed value

   localparam logic [WB:0] ONE_Q = (WB+1)'(1) << FB;
   localparam longint HALF_Q     = longint'(1) << (FB - 1);
   localparam longint SMOOTH_MAX = (longint'(1) << (SB - 1)) - 1;
   localparam longint SMOOTH_MIN = -(longint'(1) << (SB - 1));
   localparam longint VEL_MAX    = (longint'(1) << (VB - 1)) - 1;
   localparam longint VEL_MIN    = -(longint'(1) << (VB - 1));

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_DIFF  = 9'b000000010,
      S_MUL   = 9'b000000100,
      S_CHECK = 9'b000001000,
      S_DIV   = 9'b000010000,
      S_FILT1 = 9'b000100000,
      S_FILT2 = 9'b001000000,
      S_FILT3 = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // registers
   logic [LB-1:0] limit_ff;
   logic [WB-1:0] weight_ff;

   // tracking state
   logic [TB-1:0]        last_time_ff;
   logic signed [PB-1:0] last_pos_ff;
   logic signed [VB-1:0] last_vel_ff;
   logic signed [SB-1:0] smooth_ff, smooth_in;

   // per-transaction datapath
   logic [TB-1:0]         now_ff;
   logic [TB-1:0]         dt_ff, dt_in;
   logic                  dt_zero_ff;
   logic                  neg_ff;
   logic [PB:0]           mag_ff, mag_in;
   logic signed [PB:0]    diff;
   logic [NB-1:0]         prod_ff;
   logic [BB-1:0]         bound_ff;
   logic [BB-1:0]         prod_full;
   logic [LB:0]           limit_plus;
   logic signed [VB-1:0]  vel_ff, vel_in;
   logic signed [P1B-1:0] p1_ff, p1_round;
   logic signed [P2B-1:0] p2_ff;
   logic [WB:0]           weight_comp;
   logic signed [SUMB-1:0] sum;
   logic signed [FRB-1:0] smooth_round;
   logic signed [VB:0]    filt_wide;
   logic signed [VB-1:0]  filt_ff, filt_in;

   // output register
   logic                 rsp_valid_ff;
   logic                 out_load;
   emvt_pkg::track_type  rsp_trk_ff;
   logic signed [VB-1:0] rsp_vel_ff;
   logic signed [VB-1:0] rsp_filt_ff;

   logic                     req_take;
   logic                     div_start;
   logic [QB-1:0]            div_quot;
   emvt_pkg::div_status_type div_status;
   emvt_pkg::track_type      trk;

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_take     = req_if.valid && req_if.ready;

   emvt_tracker #(
      .ANGLE_BITS(ANGLE_BITS)
   ) u_tracker (
      .clock          (clock),
      .reset          (reset),
      .step           (req_take),
      .raw_angle      (req_if.raw_angle),
      .at_bottom_limit(req_if.at_bottom_limit),
      .trk            (trk)
   );

   emvt_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(prod_ff),
      .divisor (dt_ff),
      .quotient(div_quot),
      .status  (div_status)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= emvt_pkg::VELOCITY_LIMIT_RESET;
         weight_ff <= emvt_pkg::FILTER_WEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            emvt_pkg::REG_VELOCITY_LIMIT: limit_ff  <= csr_wdata[LB-1:0];
            emvt_pkg::REG_FILTER_WEIGHT:  weight_ff <= csr_wdata[WB-1:0];
            default: ;
         endcase
      end
   end

   // datapath arithmetic per step
   always_comb begin
      // position change, 33-bit signed, and elapsed time modulo 2^32
      diff   = $signed({trk.position[PB-1], trk.position}) -
               $signed({last_pos_ff[PB-1], last_pos_ff});
      mag_in = diff[PB] ? (PB+1)'(-diff) : (PB+1)'(diff);
      dt_in  = now_ff - last_time_ff;

      // |diff| * 1e6 stays below 2^52; bound = (limit + 1) * dt
      prod_full  = BB'(mag_ff) * BB'(emvt_pkg::MICROS_PER_SEC);
      limit_plus = (LB+1)'(limit_ff) + (LB+1)'(1);

      // quotient is known to be at most the limit once the divide runs
      vel_in = neg_ff ? VB'(-(VB'(div_quot))) : VB'(div_quot);

      weight_comp = ONE_Q - (WB+1)'(weight_ff);

      // floor((s*w + half) / 2^16) plus raw * (1 - w), clamp to 37 bits
      p1_round = p1_ff + P1B'(HALF_Q);
      sum      = SUMB'(p2_ff) + SUMB'($signed(p1_round[P1B-1:FB]));
      if (sum > SMOOTH_MAX) begin
         smooth_in = SB'(SMOOTH_MAX);
      end else if (sum < SMOOTH_MIN) begin
         smooth_in = SB'(SMOOTH_MIN);
      end else begin
         smooth_in = sum[SB-1:0];
      end

      // round half up to an integer, clamp to 21 bits
      smooth_round = FRB'(smooth_ff) + FRB'(HALF_Q);
      filt_wide    = smooth_round[FRB-1:FB];
      if (filt_wide > VEL_MAX) begin
         filt_in = VB'(VEL_MAX);
      end else if (filt_wide < VEL_MIN) begin
         filt_in = VB'(VEL_MIN);
      end else begin
         filt_in = filt_wide[VB-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         S_IDLE:  if (req_take) state_in = S_DIFF;
         S_DIFF:  state_in = S_MUL;
         S_MUL:   state_in = S_CHECK;
         S_CHECK: begin
            if (dt_zero_ff || ({1'b0, prod_ff} >= bound_ff)) begin
               state_in = S_FILT1;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV:   if (div_status.done) state_in = S_FILT1;
         S_FILT1: state_in = S_FILT2;
         S_FILT2: state_in = S_FILT3;
         S_FILT3: state_in = S_DONE;
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control and tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         last_time_ff <= '0;
         last_pos_ff  <= '0;
         last_vel_ff  <= '0;
         smooth_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == S_DIFF) begin
            last_time_ff <= now_ff;
            last_pos_ff  <= trk.position;
         end
         if (state_ff == S_FILT2) begin
            smooth_ff   <= smooth_in;
            last_vel_ff <= vel_ff;
         end
      end
   end

   // per-transaction payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         now_ff <= req_if.time_us;
      end
      if (state_ff == S_DIFF) begin
         dt_ff      <= dt_in;
         dt_zero_ff <= (dt_in == '0);
         mag_ff     <= mag_in;
         neg_ff     <= diff[PB];
      end
      if (state_ff == S_MUL) begin
         prod_ff  <= prod_full[NB-1:0];
         bound_ff <= BB'(limit_plus) * BB'(dt_ff);
      end
      if (state_ff == S_CHECK && !div_start) begin
         vel_ff <= last_vel_ff;
      end
      if (state_ff == S_DIV && div_status.done) begin
         vel_ff <= vel_in;
      end
      if (state_ff == S_FILT1) begin
         p1_ff <= P1B'(smooth_ff) * $signed(P1B'({1'b0, weight_ff}));
         p2_ff <= P2B'(vel_ff) * $signed(P2B'(weight_comp));
      end
      if (state_ff == S_FILT3) begin
         filt_ff <= filt_in;
      end
      if (out_load) begin
         rsp_trk_ff  <= trk;
         rsp_vel_ff  <= vel_ff;
         rsp_filt_ff <= filt_ff;
      end
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.quadrant          = rsp_trk_ff.quadrant;
   assign rsp_if.turn_count        = rsp_trk_ff.turn_count;
   assign rsp_if.position_counts   = rsp_trk_ff.position;
   assign rsp_if.raw_velocity      = rsp_vel_ff;
   assign rsp_if.filtered_velocity = rsp_filt_ff;

   // checks
   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == S_DIFF)
      else $error("accepted transaction did not start the sequencer");

   a_div_running: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> div_status.busy || div_status.done)
      else $error("sequencer waits on an idle divider");

   a_div_done_owned: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide step");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside the completion step");

endmodule

/* bench/encoder_track_checker.sv */
// Checker: predicts tracker results from accepted readings and compares them with the responses.
`timescale 1ns / 1ps

module encoder_track_checker #(
   parameter int ANGLE_BITS = emvt_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   emvt_req_if                                 req_if,
   emvt_rsp_if                                 rsp_if,
   input  logic                                csr_we,
   input  logic [emvt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [emvt_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                  fail_count,
   output int                                  pending_count
);

   localparam logic [emvt_pkg::QUAD_BITS-1:0] QUAD_SECOND = 2'd1;
   localparam logic [emvt_pkg::QUAD_BITS-1:0] QUAD_THIRD  = 2'd2;
   localparam longint ONE_Q16  = 65536;
   localparam longint HALF_Q16 = 32768;
   localparam longint S37_MAX  = (longint'(1) << 36) - 1;
   localparam longint S37_MIN  = -(longint'(1) << 36);
   localparam longint S21_MAX  = 1048575;
   localparam longint S21_MIN  = -1048576;

   typedef struct packed {
      logic [emvt_pkg::QUAD_BITS-1:0]        quadrant;
      logic signed [emvt_pkg::TURN_BITS-1:0] turn_count;
      logic signed [emvt_pkg::POS_BITS-1:0]  position;
      logic signed [emvt_pkg::VEL_BITS-1:0]  raw_velocity;
      logic signed [emvt_pkg::VEL_BITS-1:0]  filtered_velocity;
   } reading_result_type;

   reading_result_type expected_readings[$];
   int mismatches = 0;

   // tracker state and registers
   logic [emvt_pkg::LIMIT_BITS-1:0]       vel_limit;
   logic [emvt_pkg::WEIGHT_BITS-1:0]      keep_weight;
   logic [emvt_pkg::QUAD_BITS-1:0]        prev_quad;
   logic signed [emvt_pkg::TURN_BITS-1:0] turn_acc;
   longint                                home_ofs;
   longint                                prev_pos;
   logic [emvt_pkg::TIME_BITS-1:0]        prev_stamp;
   longint                                prev_vel;
   longint                                smooth_q16;

   function automatic reading_result_type track_reading(
         input logic [emvt_pkg::RAW_ANGLE_BITS-1:0] raw,
         input logic home,
         input logic [emvt_pkg::TIME_BITS-1:0] stamp);
      longint full, a, vel, w, s, f;
      int pos32;
      logic [emvt_pkg::QUAD_BITS-1:0] q;
      logic [emvt_pkg::TIME_BITS-1:0] dt;
      reading_result_type r;
      full = longint'(1) << ANGLE_BITS;
      a = full - (longint'({52'd0, raw}) & (full - 1));
      if (a < full / 4)
         q = emvt_pkg::QUAD_FIRST;
      else if (a < full / 2)
         q = QUAD_SECOND;
      else if (a < (full / 4) * 3)
         q = QUAD_THIRD;
      else
         q = emvt_pkg::QUAD_LAST;

      if (prev_quad == emvt_pkg::QUAD_LAST && q == emvt_pkg::QUAD_FIRST) begin
         if (turn_acc != emvt_pkg::TURN_MAX) turn_acc = turn_acc + 16'sd1;
      end else if (prev_quad == emvt_pkg::QUAD_FIRST && q == emvt_pkg::QUAD_LAST) begin
         if (turn_acc != emvt_pkg::TURN_MIN) turn_acc = turn_acc - 16'sd1;
      end
      prev_quad = q;

      if (home) begin
         home_ofs = a;
         turn_acc = '0;
         pos32 = 0;
      end else begin
         pos32 = int'(a + full * longint'(turn_acc) - home_ofs);
      end

      dt = stamp - prev_stamp;
      if (dt == '0) begin
         vel = prev_vel;
      end else begin
         vel = ((longint'(pos32) - prev_pos) * 1000000) / longint'({32'd0, dt});
         if (vel > longint'({44'd0, vel_limit}) || vel < -longint'({44'd0, vel_limit}))
            vel = prev_vel;
      end

      // Q16 exponential filter, floor division by arithmetic shift
      w = longint'({48'd0, keep_weight});
      s = vel * (ONE_Q16 - w) + ((smooth_q16 * w + HALF_Q16) >>> 16);
      if (s > S37_MAX) s = S37_MAX;
      if (s < S37_MIN) s = S37_MIN;
      smooth_q16 = s;
      f = (s + HALF_Q16) >>> 16;
      if (f > S21_MAX) f = S21_MAX;
      if (f < S21_MIN) f = S21_MIN;

      prev_vel = vel;
      prev_stamp = stamp;
      prev_pos = longint'(pos32);

      r.quadrant = q;
      r.turn_count = turn_acc;
      r.position = pos32;
      r.raw_velocity = vel[emvt_pkg::VEL_BITS-1:0];
      r.filtered_velocity = f[emvt_pkg::VEL_BITS-1:0];
      return r;
   endfunction

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      reading_result_type want;
      if (reset) begin
         vel_limit = emvt_pkg::VELOCITY_LIMIT_RESET;
         keep_weight = emvt_pkg::FILTER_WEIGHT_RESET;
         prev_quad = emvt_pkg::QUAD_FIRST;
         turn_acc = '0;
         home_ofs = 0;
         prev_pos = 0;
         prev_stamp = '0;
         prev_vel = 0;
         smooth_q16 = 0;
         expected_readings.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               emvt_pkg::REG_VELOCITY_LIMIT:
                  vel_limit = csr_wdata[emvt_pkg::LIMIT_BITS-1:0];
               emvt_pkg::REG_FILTER_WEIGHT:
                  keep_weight = csr_wdata[emvt_pkg::WEIGHT_BITS-1:0];
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready)
            expected_readings.push_back(track_reading(req_if.raw_angle, req_if.at_bottom_limit,
                                                      req_if.time_us));
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_readings.size() == 0) begin
               $display("%0t: result with no reading outstanding", $time);
               mismatches++;
            end else begin
               want = expected_readings.pop_front();
               check_field("quadrant", 32'(want.quadrant), 32'(rsp_if.quadrant));
               check_field("turn_count", 32'(want.turn_count), 32'(rsp_if.turn_count));
               check_field("position_counts", want.position, rsp_if.position_counts);
               check_field("raw_velocity", 32'(want.raw_velocity), 32'(rsp_if.raw_velocity));
               check_field("filtered_velocity", 32'(want.filtered_velocity),
                           32'(rsp_if.filtered_velocity));
            end
         end
      end
      fail_count <= mismatches;
      pending_count <= expected_readings.size();
   end

endmodule

/* bench/multiturn_encoder_velocity_tracker_tb.sv */
// Testbench top: drives readings and register writes into the tracker and reports the verdict.
`timescale 1ns / 1ps

module multiturn_encoder_velocity_tracker_tb;

   // inverted angle spans 1..FULL_TURN
   localparam int FULL_TURN    = 1 << emvt_pkg::ANGLE_BITS_DEFAULT;
   localparam int PHASE_ITEMS  = 180;

   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC, RX_HOLD} rx_mode_type;

   logic                                clock;
   logic                                reset;
   logic                                csr_we;
   logic [emvt_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [emvt_pkg::CSR_DATA_BITS-1:0]  csr_wdata;

   emvt_req_if req_if ();
   emvt_rsp_if rsp_if ();

   int fail_count;
   int pending_count;

   int                             burst_left;
   logic [emvt_pkg::TIME_BITS-1:0] stamp_us;

   multiturn_encoder_velocity_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   encoder_track_checker tracker_check (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_if),
      .rsp_if        (rsp_if),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Inverted angle a (1..FULL_TURN) back to the sensor's raw code.
   function automatic logic [emvt_pkg::RAW_ANGLE_BITS-1:0] raw_of(input int a);
      return emvt_pkg::RAW_ANGLE_BITS'((FULL_TURN - a) & (FULL_TURN - 1));
   endfunction

   function automatic int wrap_angle(input int a);
      int m;
      m = (a - 1) % FULL_TURN;
      if (m < 0) m += FULL_TURN;
      return m + 1;
   endfunction

   // One reading: offered from this edge until accepted. The timestamp advances by dt.
   // The sender runs in bursts with idle gaps between them.
   task automatic send_reading(input logic [emvt_pkg::RAW_ANGLE_BITS-1:0] raw,
                               input logic home,
                               input logic [emvt_pkg::TIME_BITS-1:0] dt);
      stamp_us = stamp_us + dt;
      req_if.valid           <= 1'b1;
      req_if.raw_angle       <= raw;
      req_if.at_bottom_limit <= home;
      req_if.time_us         <= stamp_us;
      do @(posedge clock); while (!req_if.ready);
      burst_left--;
      if (burst_left <= 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(12, 1)) @(posedge clock);
         // now and then a long burst, so whole stretches run without gaps
         burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(120, 50)
                                                 : $urandom_range(20, 1);
      end
   endtask

   // Stop offering, wait for every outstanding result, then let the sequencer settle.
   task automatic settle_idle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
   endtask

   // Both registers, back to back; only called with the block idle.
   task automatic write_settings(input logic [emvt_pkg::LIMIT_BITS-1:0] limit,
                                 input logic [emvt_pkg::WEIGHT_BITS-1:0] weight);
      csr_we    <= 1'b1;
      csr_index <= emvt_pkg::REG_VELOCITY_LIMIT;
      csr_wdata <= emvt_pkg::CSR_DATA_BITS'(limit);
      @(posedge clock);
      csr_index <= emvt_pkg::REG_FILTER_WEIGHT;
      csr_wdata <= emvt_pkg::CSR_DATA_BITS'(weight);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Hand-picked readings, default registers (limit 409600). Quadrant edges, both
   // wrap directions, the exact velocity bound, zero and wrapped elapsed time, homing.
   task automatic run_directed();
      send_reading(raw_of(FULL_TURN), 1'b1, 0);     // top of range homes in the last quadrant
      send_reading(raw_of(1), 1'b0, 0);             // wrap up a turn, no time elapsed
      send_reading(raw_of(1023), 1'b0, 1000);       // spike, previous velocity kept
      send_reading(raw_of(1024), 1'b0, 1);
      send_reading(raw_of(2047), 1'b0, 7);
      send_reading(raw_of(2048), 1'b0, 1000000);
      send_reading(raw_of(3071), 1'b0, 3);
      send_reading(raw_of(3072), 1'b0, 65536);
      send_reading(raw_of(1000), 1'b0, 1000);       // wrap up again
      send_reading(raw_of(2024), 1'b0, 2500);       // +1024 in 2500 us: exactly the bound
      send_reading(raw_of(1000), 1'b0, 2500);       // exactly minus the bound
      send_reading(raw_of(2024), 1'b0, 2499);       // just over the bound
      send_reading(raw_of(10), 1'b0, 100);
      send_reading(raw_of(4000), 1'b0, 100);        // wrap down a turn
      send_reading(raw_of(4000), 1'b0, 0);
      send_reading(12'hAAA, 1'b0, 32'hFFFF_FFFF);   // timestamp steps back: huge dt
      send_reading(12'h555, 1'b0, 5);
      send_reading(raw_of(2500), 1'b1, 100);        // home mid-turn
      send_reading(raw_of(2600), 1'b0, 100);
      send_reading(raw_of(2600), 1'b1, 0);          // home again, no time
      send_reading(12'hFFF, 1'b0, 32'h8000_0000);
      send_reading(raw_of(1), 1'b0, 1);
   endtask

   // Mostly steady rotations with random speed and sample spacing, plus bursts of
   // junk: random angles, random homing, zero, huge and wrapping time steps.
   task automatic run_random(input int count);
      int left, len, step, jitter, dt_lo, dt_hi, a;
      logic [emvt_pkg::TIME_BITS-1:0] dt;
      left = count;
      a = $urandom_range(FULL_TURN, 1);
      while (left > 0) begin
         if ($urandom_range(9, 0) < 7) begin
            case ($urandom_range(2, 0))
               0: begin        // creeping: tiny steps, tiny spacing, near full-scale speed
                  step = $urandom_range(16, 0) - 8;
                  dt_lo = 1;
                  dt_hi = 20;
               end
               1: begin        // moderate: mostly within the bound
                  step = $urandom_range(600, 0) - 300;
                  dt_lo = 800;
                  dt_hi = 4000;
               end
               default: begin  // fast: many spikes
                  step = $urandom_range(1800, 0) - 900;
                  dt_lo = 100;
                  dt_hi = 2000;
               end
            endcase
            len = $urandom_range(40, 8);
            for (int k = 0; k < len && left > 0; k++) begin
               jitter = $urandom_range(4, 0) - 2;
               a = wrap_angle(a + step + jitter);
               send_reading(raw_of(a), $urandom_range(59, 0) == 0, $urandom_range(dt_hi, dt_lo));
               left--;
            end
         end else begin
            len = $urandom_range(6, 1);
            for (int k = 0; k < len && left > 0; k++) begin
               case ($urandom_range(3, 0))
                  0:       dt = '0;
                  1:       dt = $urandom;
                  2:       dt = 32'hFFFF_FFFF;
                  default: dt = $urandom_range(3, 1);
               endcase
               send_reading(emvt_pkg::RAW_ANGLE_BITS'($urandom), 1'($urandom), dt);
               left--;
            end
         end
      end
   endtask

   // Stimulus: directed readings, random traffic under several register settings,
   // then the verdict.
   initial begin
      logic [emvt_pkg::LIMIT_BITS-1:0]  limits  [5];
      logic [emvt_pkg::WEIGHT_BITS-1:0] weights [5];
      limits[0]              = 20'd1048575;
      limits[1]              = 20'd0;
      limits[2]              = 20'd1048575;
      limits[3]              = 20'd1000;
      limits[4]              = emvt_pkg::VELOCITY_LIMIT_RESET;
      weights[0]             = 16'd0;
      weights[1]             = 16'd65535;
      weights[2]             = 16'd65535;
      weights[3]             = 16'd32768;
      weights[4]             = emvt_pkg::FILTER_WEIGHT_RESET;
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_index              = emvt_pkg::REG_VELOCITY_LIMIT;
      csr_wdata              = '0;
      req_if.valid           = 1'b0;
      req_if.raw_angle       = '0;
      req_if.at_bottom_limit = 1'b0;
      req_if.time_us         = '0;
      stamp_us               = '0;
      burst_left             = 8;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset values of the registers first
      run_directed();
      run_random(PHASE_ITEMS);
      settle_idle();

      // five fixed settings, then two random settings
      for (int p = 0; p < 7; p++) begin
         if (p < 5)
            write_settings(limits[p], weights[p]);
         else
            write_settings(($urandom_range(1, 0) == 0)
                              ? emvt_pkg::LIMIT_BITS'($urandom_range(600000, 1))
                              : emvt_pkg::LIMIT_BITS'($urandom),
                           emvt_pkg::WEIGHT_BITS'($urandom));
         run_random(PHASE_ITEMS);
         settle_idle();
      end

      run_random(20);

      settle_idle();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("multiturn_encoder_velocity_tracker_tb: clean");
      else
         $display("multiturn_encoder_velocity_tracker_tb: errors");
      $finish;
   end

   // Receiver: stall pattern changes per phase. Every twelfth phase is a long
   // hold-off, so the output register and the sequencer both fill and the
   // block drops req ready while the sender keeps offering.
   initial begin
      rx_mode_type mode;
      int span, phase_no;
      rsp_if.ready = 1'b0;
      phase_no = 0;
      forever begin
         phase_no++;
         if (phase_no % 12 == 5) begin
            mode = RX_HOLD;
            span = $urandom_range(400, 250);
         end else begin
            mode = rx_mode_type'($urandom_range(3, 0));
            span = $urandom_range(200, 20);
         end
         for (int k = 0; k < span; k++) begin
            @(posedge clock);
            case (mode)
               RX_OPEN:     rsp_if.ready <= 1'b1;
               RX_COIN:     rsp_if.ready <= 1'($urandom);
               RX_SPARSE:   rsp_if.ready <= ($urandom_range(3, 0) == 0);
               RX_PERIODIC: rsp_if.ready <= (k % 5 != 0);
               default:     rsp_if.ready <= 1'b0;
            endcase
         end
      end
   end

   // Watchdog: ~1.5k transactions, each at most one sequencer pass plus a hold-off.
   initial begin
      #5_000_000;
      $display("multiturn_encoder_velocity_tracker_tb: errors");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/emvt_pkg.sv
hw/rtl/emvt_if.sv
hw/rtl/emvt_tracker.sv
hw/rtl/emvt_divider.sv
hw/rtl/multiturn_encoder_velocity_tracker.sv
bench/encoder_track_checker.sv
bench/multiturn_encoder_velocity_tracker_tb.sv
